>>> hw/rtl/bmde_pkg.sv
// Package for the binary morphology dilate/erode unit.
// Holds sizes, register codes, the configuration struct and the cell control struct.
// No dependencies.
package bmde_pkg;

   // Structuring element and image limits
   localparam int MAX_SE   = 5;
   localparam int HALF     = MAX_SE / 2;
   localparam int WIN      = 2 * HALF + 1;
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int LS_DEPTH = MAX_COLS + 2 * HALF;
   localparam int LS_AW    = $clog2(LS_DEPTH);
   localparam int MASK_W   = MAX_SE * MAX_SE;
   localparam int MIDX_W   = $clog2(MASK_W);
   localparam int HALF_W   = $clog2(HALF + 1);

   // Field widths fixed by the register map
   localparam int POS_W  = 11;
   localparam int SE_W   = 3;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 5;
   localparam int IDX_W  = 3;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
   localparam logic [IDX_W-1:0] REG_SE_MASK    = 3'd1;
   localparam logic [IDX_W-1:0] REG_SE_ROWS    = 3'd2;
   localparam logic [IDX_W-1:0] REG_SE_COLS    = 3'd3;
   localparam logic [IDX_W-1:0] REG_IMAGE_ROWS = 3'd4;
   localparam logic [IDX_W-1:0] REG_IMAGE_COLS = 3'd5;

   // Mode codes
   localparam logic MODE_DILATE = 1'b0;
   localparam logic MODE_ERODE  = 1'b1;

   // Clamped configuration and derived grid limits
   typedef struct packed {
      logic              mode;
      logic [MASK_W-1:0] mask;
      logic [SE_W-1:0]   er;
      logic [SE_W-1:0]   ec;
      logic [HALF_W-1:0] hr;
      logic [HALF_W-1:0] hc;
      logic [POS_W-1:0]  ir;
      logic [POS_W-1:0]  ic;
      logic [POS_W-1:0]  hr2;         // 2*hr
      logic [POS_W-1:0]  hc2;         // 2*hc
      logic [POS_W-1:0]  row_end;     // last grid row
      logic [POS_W-1:0]  col_end;     // last grid column
      logic [POS_W-1:0]  ero_row_end; // last grid row carrying an erosion result
      logic [POS_W-1:0]  ero_col_end; // last grid column carrying an erosion result
   } cfg_type;

   // Per-cell element masks
   typedef struct packed {
      logic [WIN-1:0] dil_m; // bit a: element bit (a, j) in use
      logic [WIN-1:0] ero_m; // bit r: element bit (2hr-r, 2hc-j) in use
   } cell_mask_type;

endpackage

>>> hw/rtl/bmde_req_if.sv
// Input pixel channel: valid/ready handshake with one pixel bit.
// Depends on nothing.
interface bmde_req_if;
   logic valid;
   logic ready;
   logic pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

>>> hw/rtl/bmde_rsp_if.sv
// Result channel: valid/ready handshake with result bit, position and frame end.
// Depends on bmde_pkg.
interface bmde_rsp_if import bmde_pkg::*; ;
   logic             valid;
   logic             ready;
   logic             out_pixel;
   logic [POS_W-1:0] out_row;
   logic [POS_W-1:0] out_col;
   logic             frame_end;

   modport source (output valid, output out_pixel, output out_row, output out_col,
                   output frame_end, input ready);
   modport sink   (input valid, input out_pixel, input out_row, input out_col,
                   input frame_end, output ready);
endinterface

>>> hw/rtl/bmde_csr.sv
// APB-style register file for the morphology unit, with clamping of sizes.
// Depends on bmde_pkg.
module bmde_csr import bmde_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic              wr_hit,   // a listed register was written
   output cfg_type           cfg
);

   logic              mode_ff, mode_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [SE_W-1:0]   se_rows_ff, se_rows_in;
   logic [SE_W-1:0]   se_cols_ff, se_cols_in;
   logic [POS_W-1:0]  img_rows_ff, img_rows_in;
   logic [POS_W-1:0]  img_cols_ff, img_cols_in;
   logic              wr_en;
   logic [IDX_W-1:0]  idx;
   logic [SE_W-1:0]   er, ec;
   logic [HALF_W-1:0] hr, hc;
   logic [POS_W-1:0]  ir, ic, hr2, hc2;

   assign pready = 1'b1;
   assign idx    = paddr[ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;

   // Register writes
   always_comb begin
      mode_in     = mode_ff;
      mask_in     = mask_ff;
      se_rows_in  = se_rows_ff;
      se_cols_in  = se_cols_ff;
      img_rows_in = img_rows_ff;
      img_cols_in = img_cols_ff;
      wr_hit      = 1'b0;
      if (wr_en) begin
         unique case (idx)
            REG_MODE: begin
               mode_in = pwdata[0];
               wr_hit  = 1'b1;
            end
            REG_SE_MASK: begin
               mask_in = pwdata[MASK_W-1:0];
               wr_hit  = 1'b1;
            end
            REG_SE_ROWS: begin
               se_rows_in = pwdata[SE_W-1:0];
               wr_hit     = 1'b1;
            end
            REG_SE_COLS: begin
               se_cols_in = pwdata[SE_W-1:0];
               wr_hit     = 1'b1;
            end
            REG_IMAGE_ROWS: begin
               img_rows_in = pwdata[POS_W-1:0];
               wr_hit      = 1'b1;
            end
            REG_IMAGE_COLS: begin
               img_cols_in = pwdata[POS_W-1:0];
               wr_hit      = 1'b1;
            end
            default: wr_hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_DILATE;
         mask_ff     <= '1;
         se_rows_ff  <= SE_W'(3);
         se_cols_ff  <= SE_W'(3);
         img_rows_ff <= POS_W'(MAX_ROWS);
         img_cols_ff <= POS_W'(MAX_COLS);
      end else begin
         mode_ff     <= mode_in;
         mask_ff     <= mask_in;
         se_rows_ff  <= se_rows_in;
         se_cols_ff  <= se_cols_in;
         img_rows_ff <= img_rows_in;
         img_cols_ff <= img_cols_in;
      end
   end

   // Read-back
   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_MODE:       prdata[0]          = mode_ff;
         REG_SE_MASK:    prdata[MASK_W-1:0] = mask_ff;
         REG_SE_ROWS:    prdata[SE_W-1:0]   = se_rows_ff;
         REG_SE_COLS:    prdata[SE_W-1:0]   = se_cols_ff;
         REG_IMAGE_ROWS: prdata[POS_W-1:0]  = img_rows_ff;
         REG_IMAGE_COLS: prdata[POS_W-1:0]  = img_cols_ff;
         default:        prdata             = '0;
      endcase
   end

   // Saturate sizes into range
   always_comb begin
      if (se_rows_ff == '0)                   er = SE_W'(1);
      else if (se_rows_ff > SE_W'(MAX_SE))    er = SE_W'(MAX_SE);
      else                                    er = se_rows_ff;
      if (se_cols_ff == '0)                   ec = SE_W'(1);
      else if (se_cols_ff > SE_W'(MAX_SE))    ec = SE_W'(MAX_SE);
      else                                    ec = se_cols_ff;
      if (img_rows_ff == '0)                  ir = POS_W'(1);
      else if (img_rows_ff > POS_W'(MAX_ROWS)) ir = POS_W'(MAX_ROWS);
      else                                    ir = img_rows_ff;
      if (img_cols_ff == '0)                  ic = POS_W'(1);
      else if (img_cols_ff > POS_W'(MAX_COLS)) ic = POS_W'(MAX_COLS);
      else                                    ic = img_cols_ff;
   end

   assign hr  = HALF_W'(er >> 1);
   assign hc  = HALF_W'(ec >> 1);
   assign hr2 = POS_W'({hr, 1'b0});
   assign hc2 = POS_W'({hc, 1'b0});

   // Derived grid limits
   always_comb begin
      cfg.mode        = mode_ff;
      cfg.mask        = mask_ff;
      cfg.er          = er;
      cfg.ec          = ec;
      cfg.hr          = hr;
      cfg.hc          = hc;
      cfg.ir          = ir;
      cfg.ic          = ic;
      cfg.hr2         = hr2;
      cfg.hc2         = hc2;
      cfg.row_end     = ir + hr2 - POS_W'(1);
      cfg.col_end     = ic + hc2 - POS_W'(1);
      cfg.ero_row_end = ir + POS_W'(hr) - POS_W'(1);
      cfg.ero_col_end = ic + POS_W'(hc) - POS_W'(1);
   end

endmodule

>>> hw/rtl/bmde_line_buf.sv
// Line store: per grid column, the bits of the previous rows of the window.
// One write and one registered read per cycle, with same-address forwarding.
// Depends on bmde_pkg.
module bmde_line_buf import bmde_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [LS_AW-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [LS_AW-1:0] wr_addr,
   input  logic [WIN-2:0]   wr_data,
   output logic [WIN-2:0]   rd_data
);

   logic [WIN-2:0] mem [LS_DEPTH];
   logic [WIN-2:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a write to the same column in the same cycle wins
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bmde_cell.sv
// One window column cell: holds a column of the neighbourhood and passes it on.
// Reports its dilation hit and erosion pass on the column being loaded.
// Depends on bmde_pkg.
module bmde_cell import bmde_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          shift_en,
   input  logic          clr,       // start of a grid row: drop stale column
   input  logic [WIN-1:0] col_in,
   input  cell_mask_type msk,
   output logic [WIN-1:0] col_out,
   output logic          dil_hit,
   output logic          ero_ok
);

   logic [WIN-1:0] col_ff, col_in_next;

   assign col_in_next = clr ? '0 : col_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in_next;
      end
   end

   // Terms for the window as it stands after this shift
   assign dil_hit = |(msk.dil_m & col_in_next);
   assign ero_ok  = &(~msk.ero_m | col_in_next);
   assign col_out = col_ff;

endmodule

>>> hw/rtl/binary_morphology_dilate_erode_unit.sv
// Binary morphology unit (dilation / erosion), structuring element up to 5x5.
// An input transfer passes through the stage A registers and the result register to rsp.
// Throughput: one grid position per clock while rsp takes results; set by the line store's single write port.
// Erosion positions on the outer band of the grid give no result transfer.
// Reset (synchronous): registers to their defaults, grid position (0,0), window cleared.
// The line store is not cleared: row 0 reads zeros and rewrites every column it uses.
module binary_morphology_dilate_erode_unit import bmde_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bmde_req_if.sink          req,
   bmde_rsp_if.source        rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type cfg;
   logic    wr_hit;

   bmde_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .wr_hit  (wr_hit),
      .cfg     (cfg)
   );

   // Grid position
   logic [POS_W-1:0] row_ff, row_in, col_ff, col_in;
   logic             acc;

   // Stage A: item waiting for its line store read
   logic             a_valid_ff, a_valid_in;
   logic             a_bit_ff, a_r0_ff, a_c0_ff, a_emit_ff, a_int_ff, a_last_ff;
   logic [POS_W-1:0] a_row_ff, a_col_ff;
   logic             a_adv;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pix_ff, rsp_end_ff;
   logic [POS_W-1:0] rsp_row_ff, rsp_col_ff;

   logic             bit_now, emit_now, int_now, last_now;
   logic [WIN-2:0]   ls_rd;
   logic [WIN-1:0]   column;

   assign acc       = req.valid & req.ready;
   assign a_adv     = a_valid_ff & (~a_emit_ff | ~rsp_valid_ff | rsp.ready);
   assign req.ready = ~a_valid_ff | a_adv;

   // Position advance on each input transfer; any write to a mapped register restarts the frame
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (wr_hit) begin
         row_in = '0;
         col_in = '0;
      end else if (acc) begin
         if (col_ff == cfg.col_end) begin
            col_in = '0;
            row_in = (row_ff == cfg.row_end) ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Classify the position at input
   always_comb begin
      bit_now = req.pixel & (row_ff < cfg.ir) & (col_ff < cfg.ic);
      int_now = (row_ff >= cfg.hr2) & (row_ff < cfg.ir)
              & (col_ff >= cfg.hc2) & (col_ff < cfg.ic);
      if (cfg.mode == MODE_DILATE) begin
         emit_now = 1'b1;
         last_now = (row_ff == cfg.row_end) & (col_ff == cfg.col_end);
      end else begin
         emit_now = (row_ff >= POS_W'(cfg.hr)) & (col_ff >= POS_W'(cfg.hc))
                  & (row_ff <= cfg.ero_row_end) & (col_ff <= cfg.ero_col_end);
         last_now = (row_ff == cfg.ero_row_end) & (col_ff == cfg.ero_col_end);
      end
   end

   // Stage A registers
   assign a_valid_in = acc | (a_valid_ff & ~a_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         a_bit_ff  <= bit_now;
         a_r0_ff   <= (row_ff == '0);
         a_c0_ff   <= (col_ff == '0);
         a_emit_ff <= emit_now;
         a_int_ff  <= int_now;
         a_last_ff <= last_now;
         a_row_ff  <= (cfg.mode == MODE_DILATE) ? row_ff : row_ff - POS_W'(cfg.hr);
         a_col_ff  <= col_ff;
      end
   end

   // Line store: read on input transfer, write back the new column on advance
   logic [POS_W-1:0] a_gcol_ff;

   always_ff @(posedge clock) begin
      if (acc) begin
         a_gcol_ff <= col_ff;
      end
   end

   bmde_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (acc),
      .rd_addr (LS_AW'(col_ff)),
      .wr_en   (a_adv),
      .wr_addr (LS_AW'(a_gcol_ff)),
      .wr_data (column[WIN-2:0]),
      .rd_data (ls_rd)
   );

   assign column = {(a_r0_ff ? '0 : ls_rd), a_bit_ff};

   // Element masks per window column
   cell_mask_type msk [WIN];

   always_comb begin
      for (int j = 0; j < WIN; j++) begin
         for (int r = 0; r < WIN; r++) begin
            int a, b;
            logic [MIDX_W-1:0] idx;
            a = 2 * int'(cfg.hr) - r;
            b = 2 * int'(cfg.hc) - j;
            idx = MIDX_W'(r * MAX_SE + j);
            msk[j].dil_m[r] = (r < int'(cfg.er)) && (j < int'(cfg.ec)) && cfg.mask[idx];
            if (a >= 0 && a < int'(cfg.er) && b >= 0 && b < int'(cfg.ec)) begin
               idx = MIDX_W'(a * MAX_SE + b);
               msk[j].ero_m[r] = cfg.mask[idx];
            end else begin
               msk[j].ero_m[r] = 1'b0;
            end
         end
      end
   end

   // Row of window cells, column 0 is the newest
   logic [WIN-1:0] cell_col [WIN];
   logic [WIN-1:0] dil_hits, ero_oks;

   genvar g;
   generate
      for (g = 0; g < WIN; g++) begin : g_cell
         bmde_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (a_adv),
            .clr      ((g == 0) ? 1'b0 : a_c0_ff),
            .col_in   ((g == 0) ? column : cell_col[(g == 0) ? 0 : g - 1]),
            .msk      (msk[g]),
            .col_out  (cell_col[g]),
            .dil_hit  (dil_hits[g]),
            .ero_ok   (ero_oks[g])
         );
      end
   endgenerate

   // Result register
   assign rsp_valid_in = (a_adv & a_emit_ff) | (rsp_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv & a_emit_ff) begin
         rsp_pix_ff <= (cfg.mode == MODE_DILATE) ? |dil_hits : (a_int_ff & (&ero_oks));
         rsp_row_ff <= a_row_ff;
         rsp_col_ff <= (cfg.mode == MODE_DILATE) ? a_col_ff : a_col_ff - POS_W'(cfg.hc);
         rsp_end_ff <= a_last_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_pixel = rsp_pix_ff;
   assign rsp.out_row   = rsp_row_ff;
   assign rsp.out_col   = rsp_col_ff;
   assign rsp.frame_end = rsp_end_ff;

endmodule

>>> tb/tb_binary_morphology_dilate_erode_unit.sv
// Self-checking testbench for binary_morphology_dilate_erode_unit (dilation and erosion).
// Directed table, random frames, edge grids; checked by a behavioural predictor in this file.
// Depends on bmde_pkg, bmde_req_if, bmde_rsp_if and the unit itself.
`timescale 1ns / 1ps

module tb_binary_morphology_dilate_erode_unit;
   import bmde_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int RANDOM_ITEMS = 780;
   localparam int EDGE_ITEMS   = 40;
   localparam int SETTLE_WAIT  = 4;
   localparam int MAX_REPORTS  = 10;

   // index past the end of the register map: a write there is a no-op
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd6;

   typedef struct packed {
      logic             pix;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             fend;
   } morph_result_type;

   typedef struct packed {
      logic             given;
      morph_result_type res;
   } listed_type;

   typedef enum logic {STEP_PIXEL, STEP_WRITE} plan_step_type;

   typedef struct packed {
      plan_step_type     kind;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] data;
      logic              given;
      morph_result_type  res;
   } plan_row_type;

   // Directed table: pixel rows carry the pixel in data[0]; a typed result is used where given
   localparam int PLAN_LEN = 35;
   localparam plan_row_type DIRECTED_PLAN [PLAN_LEN] = '{
      // defaults after reset: dilation, full 3x3 element
      '{STEP_PIXEL, '0, 32'd1, 1'b1, '{1'b1, 11'd0, 11'd0, 1'b0}},
      '{STEP_PIXEL, '0, 32'd0, 1'b1, '{1'b1, 11'd0, 11'd1, 1'b0}},
      '{STEP_PIXEL, '0, 32'd0, 1'b1, '{1'b1, 11'd0, 11'd2, 1'b0}},
      // mask bit just past the element width is ignored
      '{STEP_PIXEL, '0, 32'd0, 1'b1, '{1'b0, 11'd0, 11'd3, 1'b0}},
      // zero sizes saturate to a 1x1 element over a 1x1 image
      '{STEP_WRITE, REG_IMAGE_ROWS, 32'd0, 1'b0, '0},
      '{STEP_WRITE, REG_IMAGE_COLS, 32'd0, 1'b0, '0},
      '{STEP_WRITE, REG_SE_ROWS,    32'd0, 1'b0, '0},
      '{STEP_WRITE, REG_SE_COLS,    32'd0, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd1, 1'b1, '{1'b1, 11'd0, 11'd0, 1'b1}},
      '{STEP_PIXEL, '0, 32'd0, 1'b1, '{1'b0, 11'd0, 11'd0, 1'b1}},
      '{STEP_PIXEL, '0, 32'd1, 1'b1, '{1'b1, 11'd0, 11'd0, 1'b1}},
      // empty element: dilation gives 0
      '{STEP_WRITE, REG_SE_MASK, 32'd0, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd1, 1'b1, '{1'b0, 11'd0, 11'd0, 1'b1}},
      // empty element: erosion gives 1 on the interior
      '{STEP_WRITE, REG_MODE, 32'd1, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd0, 1'b1, '{1'b1, 11'd0, 11'd0, 1'b1}},
      // stray upper data bits are dropped
      '{STEP_WRITE, REG_SE_MASK, 32'hFFFF_FFFF, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd0, 1'b1, '{1'b0, 11'd0, 11'd0, 1'b1}},
      '{STEP_PIXEL, '0, 32'd1, 1'b1, '{1'b1, 11'd0, 11'd0, 1'b1}},
      // element rows saturate to 5; 2x2 image has no interior, so erosion is all 0
      '{STEP_WRITE, REG_SE_ROWS,    32'd7, 1'b0, '0},
      '{STEP_WRITE, REG_SE_COLS,    32'd1, 1'b0, '0},
      '{STEP_WRITE, REG_IMAGE_ROWS, 32'd2, 1'b0, '0},
      '{STEP_WRITE, REG_IMAGE_COLS, 32'd2, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd1, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd1, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd1, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd1, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd1, 1'b1, '{1'b0, 11'd0, 11'd0, 1'b0}},
      '{STEP_PIXEL, '0, 32'd1, 1'b1, '{1'b0, 11'd0, 11'd1, 1'b0}},
      // write past the map mid-frame: position must carry on
      '{STEP_WRITE, REG_UNUSED, 32'hFFFF_FFFF, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd1, 1'b1, '{1'b0, 11'd1, 11'd0, 1'b0}},
      '{STEP_PIXEL, '0, 32'd1, 1'b1, '{1'b0, 11'd1, 11'd1, 1'b1}},
      '{STEP_PIXEL, '0, 32'd0, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd1, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd0, 1'b0, '0},
      '{STEP_PIXEL, '0, 32'd1, 1'b0, '0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   bmde_req_if req_ch ();
   bmde_rsp_if rsp_ch ();

   binary_morphology_dilate_erode_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor copy of the registers (raw values as written)
   logic              mir_mode     = MODE_DILATE;
   logic [MASK_W-1:0] mir_mask     = '1;
   logic [SE_W-1:0]   mir_se_rows  = 3'd3;
   logic [SE_W-1:0]   mir_se_cols  = 3'd3;
   logic [POS_W-1:0]  mir_img_rows = 11'd1024;
   logic [POS_W-1:0]  mir_img_cols = 11'd1024;

   // Predictor state: bits of earlier rows per grid column, window, grid position
   logic [WIN-2:0] line_bits [LS_DEPTH];
   logic [WIN-1:0] nbhd [WIN];
   int unsigned    grid_row = 0;
   int unsigned    grid_col = 0;

   morph_result_type due_results [$];
   listed_type       listed_results [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               req_idle_pct = 17;
   int               rsp_idle_pct = 87;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned sat_range(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // Advance the predictor by one grid position; returns 1 when a result is due
   function automatic bit morph_step(input logic pix, output morph_result_type res);
      int unsigned    er, ec, ir, ic, hr, hc, grows, gcols, r, c, i, j;
      int             k, a, b;
      logic [WIN-1:0] column;
      logic           v;
      bit             emit;
      er = sat_range(mir_se_rows, 1, MAX_SE);
      ec = sat_range(mir_se_cols, 1, MAX_SE);
      ir = sat_range(mir_img_rows, 1, MAX_ROWS);
      ic = sat_range(mir_img_cols, 1, MAX_COLS);
      hr = er / 2;
      hc = ec / 2;
      grows = ir + 2 * hr;
      gcols = ic + 2 * hc;
      if (grid_row >= grows || grid_col >= gcols) begin
         grid_row = 0;
         grid_col = 0;
      end
      r = grid_row;
      c = grid_col;

      // new column: current pixel at bit 0, earlier rows above it
      column[0] = pix && (r < ir) && (c < ic);
      column[WIN-1:1] = (r == 0) ? '0 : line_bits[c];
      if (c == 0) begin
         for (k = 0; k < WIN; k++) nbhd[k] = '0;
      end
      for (k = WIN - 1; k > 0; k--) nbhd[k] = nbhd[k-1];
      nbhd[0] = column;
      line_bits[c] = column[WIN-2:0];

      emit = 1'b0;
      res = '0;
      v = 1'b0;
      if (mir_mode == MODE_DILATE) begin
         for (a = 0; a < er; a++)
            for (b = 0; b < ec; b++)
               v |= mir_mask[a*MAX_SE+b] & nbhd[b][a];
         res = '{v, POS_W'(r), POS_W'(c), (r + 1 == grows) && (c + 1 == gcols)};
         emit = 1'b1;
      end else if (r >= hr && c >= hc && r - hr < ir && c - hc < ic) begin
         i = r - hr;
         j = c - hc;
         // border band stays 0
         if (i >= hr && i + hr < ir && j >= hc && j + hc < ic) begin
            v = 1'b1;
            for (a = 0; a < er; a++)
               for (b = 0; b < ec; b++)
                  if (mir_mask[a*MAX_SE+b] && !nbhd[2*hc-b][2*hr-a]) v = 1'b0;
         end
         res = '{v, POS_W'(i), POS_W'(j), (i + 1 == ir) && (j + 1 == ic)};
         emit = 1'b1;
      end

      c++;
      if (c >= gcols) begin
         c = 0;
         r++;
         if (r >= grows) r = 0;
      end
      grid_row = r;
      grid_col = c;
      return emit;
   endfunction

   // Random junk above a field, to show the unit drops it
   function automatic logic [DATA_W-1:0] stray_bits(int w);
      return ($urandom_range(3) == 0) ? ($urandom << w) : '0;
   endfunction

   task automatic log_fault(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endtask

   // Register write: setup then access; lands at the edge with penable and pready high
   task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_MODE:       mir_mode     = val[0];
         REG_SE_MASK:    mir_mask     = val[MASK_W-1:0];
         REG_SE_ROWS:    mir_se_rows  = val[SE_W-1:0];
         REG_SE_COLS:    mir_se_cols  = val[SE_W-1:0];
         REG_IMAGE_ROWS: mir_img_rows = val[POS_W-1:0];
         REG_IMAGE_COLS: mir_img_cols = val[POS_W-1:0];
         default: ;
      endcase
      // any mapped register restarts the frame
      if (idx <= REG_IMAGE_COLS) begin
         grid_row = 0;
         grid_col = 0;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // One pixel transfer, with random idle cycles ahead of it
   task automatic send_pixel(logic p, logic given, morph_result_type res);
      listed_results.push_back('{given, res});
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Stop sending and wait until every due result is in
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // Result sink with random back-pressure
   initial begin : result_sink
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Check result transfers, then predict from input transfers
   always @(posedge clock) begin : monitor
      morph_result_type got, want, pred;
      listed_type       entry;
      bit               has;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_pixel, rsp_ch.out_row, rsp_ch.out_col, rsp_ch.frame_end};
            if (due_results.size() == 0) begin
               log_fault($sformatf("unexpected result: pixel %0b row %0d col %0d end %0b",
                                   got.pix, got.row, got.col, got.fend));
            end else begin
               want = due_results.pop_front();
               if (got.pix !== want.pix || got.row !== want.row || got.col !== want.col ||
                   got.fend !== want.fend)
                  log_fault($sformatf({"result mismatch: expected pixel %0b row %0d col %0d ",
                                       "end %0b, got pixel %0b row %0d col %0d end %0b"},
                                      want.pix, want.row, want.col, want.fend,
                                      got.pix, got.row, got.col, got.fend));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            has = morph_step(req_ch.pixel, pred);
            entry = (listed_results.size() != 0) ? listed_results.pop_front() : '0;
            if (entry.given) due_results.push_back(entry.res);
            else if (has) due_results.push_back(pred);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type      step;
      logic [DATA_W-1:0] mask_val;
      int unsigned       er, ec, ir, ic, ticks, n, k;
      int                density, shape;
      int                random_sent;
      req_ch.valid <= 1'b0;
      req_ch.pixel <= 1'b0;
      random_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part
      for (k = 0; k < PLAN_LEN; k++) begin
         step = DIRECTED_PLAN[k];
         if (step.kind == STEP_WRITE) begin
            settle();
            cfg_write(step.idx, step.data);
         end else begin
            send_pixel(step.data[0], step.given, step.res);
         end
      end

      // random frames, idling phases switch on the item count
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent < RANDOM_ITEMS / 3) begin
            req_idle_pct = 17;
            rsp_idle_pct = 87;
         end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 87;
            rsp_idle_pct = 17;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         settle();
         case ($urandom_range(3))
            0:       mask_val = $urandom;
            1:       mask_val = '1;
            2:       mask_val = 32'd1 << $urandom_range(MASK_W - 1);
            default: mask_val = $urandom & $urandom;
         endcase
         // a random subset; with none written the frame carries on
         if ($urandom_range(9) < 7) cfg_write(REG_MODE, $urandom_range(1) | stray_bits(1));
         if ($urandom_range(9) < 7) cfg_write(REG_SE_MASK, mask_val);
         if ($urandom_range(9) < 7)
            cfg_write(REG_SE_ROWS, $urandom_range(7) | stray_bits(SE_W));
         if ($urandom_range(9) < 7)
            cfg_write(REG_SE_COLS, $urandom_range(7) | stray_bits(SE_W));
         if ($urandom_range(9) < 7)
            cfg_write(REG_IMAGE_ROWS, $urandom_range(10) | stray_bits(POS_W));
         if ($urandom_range(9) < 7)
            cfg_write(REG_IMAGE_COLS, $urandom_range(10) | stray_bits(POS_W));

         er = sat_range(mir_se_rows, 1, MAX_SE);
         ec = sat_range(mir_se_cols, 1, MAX_SE);
         ir = sat_range(mir_img_rows, 1, MAX_ROWS);
         ic = sat_range(mir_img_cols, 1, MAX_COLS);
         ticks = (ir + 2 * (er / 2)) * (ic + 2 * (ec / 2));
         shape = $urandom_range(4);
         if (shape == 0) n = $urandom_range(ticks, 1);
         else if (shape == 1) n = 2 * ticks;
         else n = ticks;
         case ($urandom_range(2))
            0:       density = 10;
            1:       density = 50;
            default: density = 92;
         endcase

         for (k = 0; k < n; k++) begin
            send_pixel($urandom_range(99) < density, 1'b0, '0);
            // occasional hold-off until the unit has drained
            if ($urandom_range(149) == 0) settle();
         end
         random_sent += n;
      end

      // widest and tallest grids, the opening positions of each
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (shape = 0; shape < 2; shape++) begin
         settle();
         cfg_write(REG_MODE, MODE_DILATE);
         cfg_write(REG_SE_MASK, $urandom);
         cfg_write(REG_SE_ROWS, (shape == 0) ? 32'd1 : 32'd5);
         cfg_write(REG_SE_COLS, (shape == 0) ? 32'd5 : 32'd1);
         cfg_write(REG_IMAGE_ROWS, (shape == 0) ? 32'd1 : 32'd1024);
         cfg_write(REG_IMAGE_COLS, (shape == 0) ? 32'd2047 : 32'd1);
         for (k = 0; k < EDGE_ITEMS; k++) send_pixel($urandom_range(1), 1'b0, '0);
      end

      settle();
      repeat (8) @(posedge clock);
      if (error_count == 0 && due_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
